FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, disabled in rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/mntr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mntr_pkg
// Types and constants of the MIDI note tone recorder.
// ----------------------------------------------------------------------------
package mntr_pkg;

  typedef struct packed {
    logic       opcode;
    logic [7:0] status_byte;
    logic [7:0] key_byte;
    logic [7:0] velocity_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  message_class;
    logic [7:0]  tone_period;
    logic [6:0]  tone_compare;
    logic        record_valid;
    logic [7:0]  record_note;
    logic [15:0] record_start;
    logic [7:0]  record_length;
    logic [7:0]  record_slot;
    logic        store_full;
  } out_item_t;

  localparam logic       OP_TICK = 1'b0;
  localparam logic       OP_MIDI = 1'b1;

  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;

  localparam logic [1:0] CLS_TICK      = 2'd0;
  localparam logic [1:0] CLS_NOTE_ON   = 2'd1;
  localparam logic [1:0] CLS_NOTE_OFF  = 2'd2;
  localparam logic [1:0] CLS_UNHANDLED = 2'd3;

  localparam logic [7:0] NOTE_LOW  = 8'd60;
  localparam logic [7:0] NOTE_HIGH = 8'd83;

  localparam logic [7:0] LEN_MAX = 8'd255;

  // 62500 / (2 * f) for the tempered scale, middle C (262 Hz) up to 988 Hz
  function automatic logic [7:0] period_for(input logic [7:0] key);
    logic [7:0] p;
    unique case (key)
      8'd60: p = 8'd119;
      8'd61: p = 8'd112;
      8'd62: p = 8'd106;
      8'd63: p = 8'd100;
      8'd64: p = 8'd94;
      8'd65: p = 8'd89;
      8'd66: p = 8'd84;
      8'd67: p = 8'd79;
      8'd68: p = 8'd75;
      8'd69: p = 8'd71;
      8'd70: p = 8'd67;
      8'd71: p = 8'd63;
      8'd72: p = 8'd59;
      8'd73: p = 8'd56;
      8'd74: p = 8'd53;
      8'd75: p = 8'd50;
      8'd76: p = 8'd47;
      8'd77: p = 8'd44;
      8'd78: p = 8'd42;
      8'd79: p = 8'd39;
      8'd80: p = 8'd37;
      8'd81: p = 8'd35;
      8'd82: p = 8'd33;
      8'd83: p = 8'd31;
      default: p = 8'd0;  // outside the table: silent
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/mntr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mntr channel interfaces
// Valid/ready channels for MIDI items in and tone/record results out.
// ----------------------------------------------------------------------------
interface mntr_in_if;
  logic               valid;
  logic               ready;
  mntr_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mntr_out_if;
  logic                valid;
  logic                ready;
  mntr_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/midi_note_tone_recorder_top.sv
`default_nettype none
// Each result is registered and appears in the cycle after its item is accepted.
// Throughput: one item per cycle; the result register lets a new item in
// whenever it is empty or being drained in the same cycle.
// Reset (rst, synchronous): counters, held note, tone period and the result
// valid flag are cleared; no clearing pass.
// ----------------------------------------------------------------------------
// midi_note_tone_recorder_top
// Counts ms ticks, sets the tone period on note-on, logs the held note and silences the tone on a matching note-off.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module midi_note_tone_recorder_top #(
  parameter int MELODY_DEPTH = 256
) (
  input  wire        clk,
  input  wire        rst,
  mntr_in_if.sink    items,
  mntr_out_if.source results
);
  import mntr_pkg::*;

  localparam int CNT_W = $clog2(MELODY_DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(MELODY_DEPTH);

  logic [31:0]      ms_counter, ms_counter_next;
  logic [31:0]      note_start_ms, note_start_ms_next;
  logic [7:0]       held_note, held_note_next;
  logic             held_valid, held_valid_next;
  logic [7:0]       period_reg, period_reg_next;
  logic [CNT_W-1:0] record_count, record_count_next;

  logic             res_valid;
  out_item_t        res_data, res_next;

  logic             in_fire;
  logic [3:0]       cmd;
  logic [31:0]      dur;
  logic             match;

  assign items.ready = !res_valid || results.ready;
  assign in_fire     = items.valid && items.ready;

  assign cmd   = items.data.status_byte[7:4];
  assign match = held_valid && (held_note == items.data.key_byte);
  assign dur   = ms_counter - note_start_ms;

  always_comb begin
    ms_counter_next    = ms_counter;
    note_start_ms_next = note_start_ms;
    held_note_next     = held_note;
    held_valid_next    = held_valid;
    period_reg_next    = period_reg;
    record_count_next  = record_count;
    res_next           = '0;

    if (items.data.opcode == OP_TICK) begin
      res_next.message_class = CLS_TICK;
      ms_counter_next        = ms_counter + 32'd1;
    end else if (cmd == CMD_NOTE_ON && items.data.velocity_byte != 8'd0) begin
      res_next.message_class = CLS_NOTE_ON;
      note_start_ms_next     = ms_counter;
      period_reg_next        = period_for(items.data.key_byte);
      held_note_next         = items.data.key_byte;
      held_valid_next        = 1'b1;
    end else if (cmd == CMD_NOTE_OFF || cmd == CMD_NOTE_ON) begin
      res_next.message_class = CLS_NOTE_OFF;
      if (match) begin
        if (record_count < DEPTH_C) begin
          res_next.record_valid  = 1'b1;
          res_next.record_note   = items.data.key_byte;
          res_next.record_start  = note_start_ms[15:0];
          res_next.record_length = (dur > 32'(LEN_MAX)) ? LEN_MAX : dur[7:0];
          res_next.record_slot   = 8'(record_count);
          record_count_next      = record_count + CNT_W'(1);
        end else begin
          res_next.store_full = 1'b1;
        end
        period_reg_next = 8'd0;
      end
    end else begin
      res_next.message_class = CLS_UNHANDLED;
    end

    res_next.tone_period  = period_reg_next;
    res_next.tone_compare = period_reg_next[7:1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_counter    <= '0;
      note_start_ms <= '0;
      held_note     <= '0;
      held_valid    <= 1'b0;
      period_reg    <= '0;
      record_count  <= '0;
      res_valid     <= 1'b0;
    end else begin
      if (in_fire) begin
        ms_counter    <= ms_counter_next;
        note_start_ms <= note_start_ms_next;
        held_note     <= held_note_next;
        held_valid    <= held_valid_next;
        period_reg    <= period_reg_next;
        record_count  <= record_count_next;
        res_valid     <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_data <= res_next;
    end
  end

  assign results.valid = res_valid;
  assign results.data  = res_data;

  `ASSERT_IMPLIES(a_count_bound, 1'b1, record_count <= DEPTH_C)
  `ASSERT_IMPLIES(a_record_is_off,
    res_valid && res_data.record_valid,
    res_data.message_class == CLS_NOTE_OFF && !res_data.store_full
      && res_data.tone_period == 8'd0)
  `ASSERT_NEXT(a_tick_counts,
    in_fire && items.data.opcode == OP_TICK,
    ms_counter == $past(ms_counter) + 32'd1 && record_count == $past(record_count))
  `ASSERT_NEXT(a_record_bumps_count,
    in_fire && res_next.record_valid,
    record_count == $past(record_count) + CNT_W'(1))

endmodule
`default_nettype wire

FILE: tb/sv/tone_record_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tone_record_checker
// Watches both channels of the MIDI note tone recorder. Each input transfer
// runs through a local model of the ms counter, held note, tone period and
// melody store; each result transfer is compared field by field against the
// oldest predicted result.
// ----------------------------------------------------------------------------
module tone_record_checker #(
  parameter int MELODY_DEPTH = 256
) (
  input  wire  clk,
  input  wire  rst,
  mntr_in_if   items,
  mntr_out_if  results,
  output int   fails,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mntr_pkg::*;

  // tempered scale, middle C upward
  int unsigned pitch_hz [0:23] = '{
    262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494,
    523, 554, 587, 622, 659, 698, 740, 784, 831, 880, 932, 988
  };

  logic [31:0] ms_count;
  logic [31:0] on_time;
  logic [7:0]  latched_key;
  logic        key_held;
  logic [7:0]  tone_top;
  int unsigned stored;

  out_item_t   awaited_results [$];
  out_item_t   want;

  function automatic logic [7:0] tone_period_of(input logic [7:0] key);
    if (key < NOTE_LOW || key > NOTE_HIGH) return 8'd0;
    return 8'(32'd62500 / (2 * pitch_hz[key - NOTE_LOW]));
  endfunction

  function automatic out_item_t predict_tone(input in_item_t it);
    out_item_t   r;
    logic [31:0] held_ms;
    r = '0;
    if (it.opcode == OP_TICK) begin
      r.message_class = CLS_TICK;
      ms_count = ms_count + 32'd1;
    end else if (it.status_byte[7:4] == CMD_NOTE_ON && it.velocity_byte != 8'd0) begin
      r.message_class = CLS_NOTE_ON;
      on_time = ms_count;
      tone_top = tone_period_of(it.key_byte);
      latched_key = it.key_byte;
      key_held = 1'b1;
    end else if (it.status_byte[7:4] == CMD_NOTE_OFF ||
                 it.status_byte[7:4] == CMD_NOTE_ON) begin
      r.message_class = CLS_NOTE_OFF;
      // latched note stays, so a repeated off measures from the same start
      if (key_held && latched_key == it.key_byte) begin
        held_ms = ms_count - on_time;
        if (stored < MELODY_DEPTH) begin
          r.record_valid  = 1'b1;
          r.record_note   = it.key_byte;
          r.record_start  = on_time[15:0];
          r.record_length = (held_ms > LEN_MAX) ? LEN_MAX : held_ms[7:0];
          r.record_slot   = 8'(stored);
          stored++;
        end else begin
          r.store_full = 1'b1;
        end
        tone_top = 8'd0;
      end
    end else begin
      r.message_class = CLS_UNHANDLED;
    end
    r.tone_period  = tone_top;
    r.tone_compare = tone_top[7:1];
    return r;
  endfunction

  task automatic check_field(input string field, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      fails++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ms_count    = '0;
      on_time     = '0;
      latched_key = '0;
      key_held    = 1'b0;
      tone_top    = '0;
      stored      = 0;
      awaited_results.delete();
    end else begin
      // compare before pushing: a result never belongs to this edge's item
      if (results.valid && results.ready) begin
        if (awaited_results.size() == 0) begin
          fails++;
          $display("%0t: result transfer with nothing expected, actual %h",
                   $time, results.data);
        end else begin
          want = awaited_results.pop_front();
          check_field("message_class", want.message_class, results.data.message_class);
          check_field("tone_period", want.tone_period, results.data.tone_period);
          check_field("tone_compare", want.tone_compare, results.data.tone_compare);
          check_field("record_valid", want.record_valid, results.data.record_valid);
          check_field("record_note", want.record_note, results.data.record_note);
          check_field("record_start", want.record_start, results.data.record_start);
          check_field("record_length", want.record_length, results.data.record_length);
          check_field("record_slot", want.record_slot, results.data.record_slot);
          check_field("store_full", want.store_full, results.data.store_full);
        end
      end
      if (items.valid && items.ready) awaited_results.push_back(predict_tone(items.data));
    end
    pending = awaited_results.size();
  end

endmodule
`default_nettype wire

FILE: tb/sv/tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Drives the MIDI note tone recorder with a short directed sequence and then
// random note phrases, broken phrases and noise, under random sender bursts
// and receiver stalls; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mntr_pkg::*;

  localparam int DEPTH     = 256;
  localparam int N_ITEMS   = 2000;
  localparam int HOLD_AT   = 1500;
  localparam int HOLD_LEN  = 400;

  // commands the block does not handle
  localparam logic [3:0] CMD_POLY_AT = 4'hA;
  localparam logic [3:0] CMD_SYSTEM  = 4'hF;
  localparam logic [3:0] CMD_DATA    = 4'h0;

  logic clk;
  logic rst;
  int   fails;
  int   pending;
  int   sent;
  int   burst_left;
  int   phrases;

  mntr_in_if  items_ch ();
  mntr_out_if results_ch ();

  midi_note_tone_recorder_top #(.MELODY_DEPTH(DEPTH)) uut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch)
  );

  tone_record_checker #(.MELODY_DEPTH(DEPTH)) checker_i (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch),
    .fails   (fails),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("FAIL midi_note_tone_recorder_top");
    $finish;
  end

  function automatic in_item_t item(input logic op, input logic [7:0] status,
                                    input logic [7:0] key, input logic [7:0] vel);
    in_item_t it;
    it.opcode        = op;
    it.status_byte   = status;
    it.key_byte      = key;
    it.velocity_byte = vel;
    return it;
  endfunction

  function automatic in_item_t cmd_item(input logic [3:0] cmd, input logic [7:0] key,
                                        input logic [7:0] vel);
    return item(OP_MIDI, {cmd, 4'($urandom)}, key, vel);
  endfunction

  function automatic in_item_t tick_item();
    return item(OP_TICK, 8'($urandom), 8'($urandom), 8'($urandom));
  endfunction

  function automatic in_item_t noise_item();
    logic [24:0] raw;
    raw = 25'($urandom);
    return raw;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(input in_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(40, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(8, 1);
      if (gap != 0) begin
        items_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    items_ch.valid <= 1'b1;
    items_ch.data  <= it;
    do @(posedge clk); while (!items_ch.ready);
    @(negedge clk);
    sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_item(tick_item());
  endtask

  // note-off by either form
  task automatic send_off(input logic [7:0] key);
    if ($urandom_range(1) == 0) send_item(cmd_item(CMD_NOTE_OFF, key, 8'($urandom)));
    else send_item(cmd_item(CMD_NOTE_ON, key, 8'd0));
  endtask

  // receiver: random stall patterns, with one long hold-off
  initial begin : drain
    int cyc;
    int mode;
    int span;
    results_ch.ready = 1'b0;
    cyc  = 0;
    span = 0;
    mode = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      cyc++;
      if (cyc == HOLD_AT) begin
        results_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end
      if (span == 0) begin
        mode = $urandom_range(3);
        span = $urandom_range(300, 40);
      end
      span--;
      case (mode)
        0: results_ch.ready <= 1'b1;
        1: results_ch.ready <= 1'($urandom_range(1));
        2: results_ch.ready <= ($urandom_range(3) == 0);
        default: results_ch.ready <= ($urandom_range(7) != 0);
      endcase
      @(negedge clk);
    end
  end

  initial begin : stim
    logic [7:0] key;
    int         pick;
    items_ch.valid = 1'b0;
    items_ch.data  = '0;
    rst            = 1'b1;
    sent           = 0;
    burst_left     = 0;
    phrases        = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed
    send_item(item(OP_TICK, 8'hFF, 8'hFF, 8'hFF));
    send_item(item(OP_MIDI, {CMD_NOTE_OFF, 4'h0}, 8'd0, 8'd0));  // off before any note
    send_item(item(OP_MIDI, {CMD_NOTE_ON, 4'h0}, NOTE_LOW, 8'h7F));
    send_ticks(3);
    send_item(item(OP_MIDI, {CMD_NOTE_OFF, 4'hF}, NOTE_LOW, 8'hFF));
    send_item(item(OP_MIDI, {CMD_NOTE_ON, 4'hF}, NOTE_HIGH, 8'd1));
    send_item(tick_item());
    send_item(item(OP_MIDI, {CMD_NOTE_ON, 4'h5}, NOTE_HIGH, 8'd0));   // on, zero velocity
    send_item(item(OP_MIDI, {CMD_NOTE_OFF, 4'hA}, NOTE_HIGH, 8'h40)); // repeated off
    send_item(item(OP_MIDI, {CMD_NOTE_ON, 4'h3}, NOTE_LOW - 8'd1, 8'hFF)); // below table
    send_item(item(OP_MIDI, {CMD_NOTE_OFF, 4'h3}, NOTE_LOW, 8'h00));  // wrong key
    send_item(item(OP_MIDI, {CMD_NOTE_OFF, 4'h3}, NOTE_LOW - 8'd1, 8'h00));
    send_item(item(OP_MIDI, {CMD_NOTE_ON, 4'h7}, NOTE_HIGH + 8'd1, 8'h80)); // above table
    send_item(item(OP_MIDI, {CMD_NOTE_ON, 4'h7}, 8'hFF, 8'h40));
    send_item(item(OP_MIDI, {CMD_NOTE_ON, 4'h7}, 8'h00, 8'h01));
    send_item(item(OP_MIDI, {CMD_NOTE_OFF, 4'h7}, 8'h00, 8'h01));
    send_item(item(OP_MIDI, {CMD_POLY_AT, 4'h0}, NOTE_LOW, 8'h7F));
    send_item(item(OP_MIDI, {CMD_SYSTEM, 4'hF}, 8'hFF, 8'hFF));
    send_item(item(OP_MIDI, {CMD_DATA, 4'h0}, 8'h00, 8'h00));
    send_item(item(OP_MIDI, 8'h7F, NOTE_HIGH, 8'h7F));
    // held past the length limit
    send_item(item(OP_MIDI, {CMD_NOTE_ON, 4'h2}, NOTE_LOW + 8'd9, 8'h64));
    send_ticks(260);
    send_item(item(OP_MIDI, {CMD_NOTE_OFF, 4'h2}, NOTE_LOW + 8'd9, 8'h00));

    // random: mostly complete phrases, runs on until the melody store overflows
    while (sent < N_ITEMS || phrases < DEPTH + 40) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        key = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(NOTE_HIGH, NOTE_LOW));
        send_item(cmd_item(CMD_NOTE_ON, key, 8'($urandom_range(255, 1))));
        // now and then hold close to or past the duration limit
        send_ticks(($urandom_range(199) == 0) ? $urandom_range(300, 250) : $urandom_range(4));
        send_off(key);
        phrases++;
        if ($urandom_range(7) == 0) send_off(key);
      end else if (pick < 88) begin
        key = 8'($urandom);
        if ($urandom_range(1) == 0)
          send_item(cmd_item(CMD_NOTE_ON, key, 8'($urandom_range(255, 1))));
        send_ticks($urandom_range(3));
        send_off(key ^ 8'($urandom_range(255, 1)));
      end else if (pick < 94) begin
        send_item(noise_item());
      end else begin
        send_item(tick_item());
      end
    end

    items_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (fails == 0) $display("PASS midi_note_tone_recorder_top");
    else $display("FAIL midi_note_tone_recorder_top");
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
+incdir+rtl
rtl/mntr_pkg.sv
rtl/mntr_if.sv
rtl/midi_note_tone_recorder_top.sv
tb/sv/tone_record_checker.sv
tb/sv/tb.sv
